[design/tasi_pkg.sv]
// Shared types, widths and helpers for the three-axis step interpolator.
package tasi_pkg;

	localparam int DELTA_BITS = 16;
	localparam int MAG_W      = DELTA_BITS - 1;
	localparam int CNT_W      = MAG_W + 1;
	localparam int PROD_W     = 2 * CNT_W;
	localparam int AXES       = 3;
	localparam int AX_W       = $clog2(AXES);
	localparam int IN_TDATA_W = ((AXES * DELTA_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;
	localparam int CFG_IDX_W  = 2;

	localparam logic REQ_MOVE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FLIP_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_Z = 2'd2;

	localparam logic [AX_W-1:0] AXIS_LAST = AX_W'(AXES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_CL,
		ST_MUL_TD,
		ST_CMP,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic            latch_move;
		logic            start_tick;
		logic            mul_cl;
		logic            mul_td;
		logic            compare;
		logic            finish;
		logic            load_out;
		logic [AX_W-1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic out_free;
	} status_t;

	// Saturating magnitude of a two's complement delta
	function automatic logic [MAG_W-1:0] magnitude(input logic [DELTA_BITS-1:0] v);
		logic [DELTA_BITS-1:0] neg;
		neg = (~v) + DELTA_BITS'(1);
		if (!v[DELTA_BITS-1])
			return v[MAG_W-1:0];
		else if (neg[DELTA_BITS-1])
			return {MAG_W{1'b1}};
		else
			return neg[MAG_W-1:0];
	endfunction

endpackage

[design/three_axis_step_interpolator_core.sv]
// Three-axis step interpolator: top level joining controller and datapath.
// A move beat or an idle tick goes straight from ST_IDLE to ST_WRITE; a tick during a move
// first runs three multiply/multiply/compare passes (ST_MUL_CL, ST_MUL_TD, ST_CMP), one per
// axis, through the shared multipliers. ST_WRITE loads the output register once it is free.
// A new beat is accepted only in ST_IDLE, after the previous result has been loaded.
// Reset (arst_n low, asynchronous) clears flips, axis state and the output valid flag.
module three_axis_step_interpolator_core import tasi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic                   cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // delta_x, delta_y, delta_z
	input  logic                   s_tuser,  // req_type
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // pulse_x, pulse_y, pulse_z, dir_out_x,
	                                         // dir_out_y, dir_out_z, busy_res, zero pad
	output logic                   m_tlast   // final_tick
);

	cmd_t    cmd;
	status_t status;

	tasi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser),
		.status   (status),
		.cmd      (cmd)
	);

	tasi_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

[design/tasi_ctrl.sv]
// Sequencing state machine for move latching and per-axis tick evaluation.
module tasi_ctrl import tasi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  logic    req_type,
	input  status_t status,
	output cmd_t    cmd
);

	state_t          state_q, state_nxt;
	logic [AX_W-1:0] axis_q;
	logic            accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_TICK && status.active)
						state_nxt = ST_MUL_CL;
					else
						state_nxt = ST_WRITE;
				end
			end
			ST_MUL_CL: state_nxt = ST_MUL_TD;
			ST_MUL_TD: state_nxt = ST_CMP;
			ST_CMP: begin
				if (axis_q == AXIS_LAST)
					state_nxt = ST_WRITE;
				else
					state_nxt = ST_MUL_CL;
			end
			ST_WRITE: begin
				if (status.out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.axis       = axis_q;
		cmd.latch_move = accept && (req_type == REQ_MOVE);
		cmd.start_tick = accept;
		case (state_q)
			ST_MUL_CL: cmd.mul_cl = 1'b1;
			ST_MUL_TD: cmd.mul_td = 1'b1;
			ST_CMP: begin
				cmd.compare = 1'b1;
				cmd.finish  = (axis_q == AXIS_LAST);
			end
			ST_WRITE: cmd.load_out = status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE)
				axis_q <= '0;
			else if (state_q == ST_CMP && axis_q != AXIS_LAST)
				axis_q <= axis_q + AX_W'(1);
		end
	end

endmodule

[design/tasi_datapath.sv]
// Axis state, shared multipliers, step test and output register.
module tasi_datapath import tasi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic                   cfg_wdata,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  cmd_t                   cmd,
	output status_t                status,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast
);

	logic [AXES-1:0]   flip_q;
	logic [AXES-1:0]   dir_q;
	logic [AXES-1:0]   pulse_q;
	logic [MAG_W-1:0]  total_q [AXES];
	logic [CNT_W-1:0]  next_q  [AXES];
	logic [CNT_W-1:0]  tick_q;
	logic [CNT_W-1:0]  t_q;
	logic [MAG_W-1:0]  longest_q;
	logic              active_q;
	logic              last_q;
	logic [PROD_W-1:0] p_cl_q;
	logic [PROD_W-1:0] p_td_q;
	logic              m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic              m_last_q;

	logic [MAG_W-1:0]  mag   [AXES];
	logic [AXES-1:0]   nonneg;
	logic [MAG_W-1:0]  max_mag;
	logic [CNT_W-1:0]  den;
	logic              fire;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			mag[i]    = magnitude(s_tdata[i*DELTA_BITS +: DELTA_BITS]);
			nonneg[i] = !s_tdata[i*DELTA_BITS + DELTA_BITS - 1];
		end
		max_mag = mag[0];
		for (int i = 1; i < AXES; i++)
			if (mag[i] > max_mag)
				max_mag = mag[i];
	end

	// ceil(c*L/d) == t  <=>  t*d - d < c*L <= t*d
	assign den  = {1'b0, total_q[cmd.axis]} + CNT_W'(1);
	assign fire = ({1'b0, next_q[cmd.axis]} <= {2'b0, total_q[cmd.axis]})
		&& (p_cl_q <= p_td_q)
		&& (({1'b0, p_cl_q} + (PROD_W + 1)'(den)) > {1'b0, p_td_q});

	assign status.active   = active_q;
	assign status.out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q    <= '0;
			dir_q     <= '0;
			pulse_q   <= '0;
			tick_q    <= '0;
			longest_q <= '0;
			active_q  <= 1'b0;
			last_q    <= 1'b0;
			m_valid_q <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				total_q[i] <= '0;
				next_q[i]  <= CNT_W'(1);
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FLIP_X: flip_q[0] <= cfg_wdata;
					REG_FLIP_Y: flip_q[1] <= cfg_wdata;
					REG_FLIP_Z: flip_q[2] <= cfg_wdata;
					default: ;
				endcase
			end

			if (cmd.start_tick) begin
				pulse_q <= '0;
				last_q  <= 1'b0;
				t_q     <= tick_q + CNT_W'(1);
			end

			if (cmd.latch_move) begin
				for (int i = 0; i < AXES; i++) begin
					total_q[i] <= mag[i];
					next_q[i]  <= CNT_W'(1);
					dir_q[i]   <= nonneg[i] ^ flip_q[i];
				end
				longest_q <= max_mag;
				tick_q    <= '0;
				active_q  <= (max_mag != '0);
			end

			if (cmd.mul_cl)
				p_cl_q <= PROD_W'(next_q[cmd.axis]) * PROD_W'(longest_q);
			if (cmd.mul_td)
				p_td_q <= PROD_W'(t_q) * PROD_W'(den);

			if (cmd.compare && fire) begin
				pulse_q[cmd.axis] <= 1'b1;
				next_q[cmd.axis]  <= next_q[cmd.axis] + CNT_W'(1);
			end

			if (cmd.finish) begin
				tick_q <= t_q;
				if (t_q >= {1'b0, longest_q}) begin
					last_q   <= 1'b1;
					active_q <= 1'b0;
				end
			end

			if (cmd.load_out)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	// beat payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_data_q <= OUT_TDATA_W'({active_q, dir_q, pulse_q});
			m_last_q <= last_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule
